FILE: rtl/core/rslr_pkg.sv
`default_nettype none

package rslr_pkg;

  // default store depth and fixed field widths
  localparam int unsigned DEPTH_DEF = 1024;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned IN_DATA_W = 72;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'b1;

  // input kinds carried on tuser
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_MUL,
    ST_LOAD_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } rslr_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/range_successor_of_line_residuals_core.sv
`default_nettype none

// channel  | ports           | carries
// ---------+-----------------+-----------------------------------------------
// input    | in_t*           | load (store residual) or query (range scan)
// result   | out_t*          | one transaction per query: found, min_value
// config   | cfg_we/addr/wd  | slope (index 0), offset (index 1), no read-back
//
// a load steps through multiply, add/abs and memory write, then returns to idle
// a query scans one stored residual per cycle through the single memory read port
// and one shared compare unit; an empty range goes straight to the result
// in_tready is high only while the sequencer is idle
// a finished result waits in the output register; a following query stalls
// only at its end if that register is still occupied
// rst_n is synchronous; the residual store is not cleared by reset

module range_successor_of_line_residuals_core #(
  parameter int unsigned DEPTH = rslr_pkg::DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // tdata: position[10:0], value[42:11], left[53:43], right[64:54], zero pad
  input  wire logic [rslr_pkg::IN_DATA_W-1:0] in_tdata,
  // tuser: func
  input  wire logic                           in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // tdata: min_value[31:0]
  output logic [rslr_pkg::VAL_W-1:0]          out_tdata,
  // tuser: found
  output logic                                out_tuser,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [rslr_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [rslr_pkg::COEF_W-1:0]    cfg_wdata
);

  import rslr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // unpack the input transaction
  logic [POS_W-1:0]        in_pos;
  logic signed [VAL_W-1:0] in_val;
  logic [POS_W-1:0]        in_left;
  logic [POS_W-1:0]        in_right;

  assign in_pos   = in_tdata[10:0];
  assign in_val   = in_tdata[42:11];
  assign in_left  = in_tdata[53:43];
  assign in_right = in_tdata[64:54];

  // configuration registers
  logic signed [COEF_W-1:0] slope_r;
  logic signed [COEF_W-1:0] offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r  <= '0;
      offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SLOPE:  slope_r  <= cfg_wdata;
        REG_OFFSET: offset_r <= cfg_wdata;
      endcase
    end
  end

  // range clamp and load address check, done in 32 bits so any depth fits
  logic [31:0] pos32, left32, right32, lo32, hi32;
  logic        load_ok;
  logic        range_empty;

  assign pos32       = 32'(in_pos);
  assign left32      = 32'(in_left);
  assign right32     = 32'(in_right);
  assign lo32        = (left32 == 32'd0) ? 32'd1 : left32;
  assign hi32        = (right32 > 32'(DEPTH)) ? 32'(DEPTH) : right32;
  assign load_ok     = (pos32 != 32'd0) && (pos32 <= 32'(DEPTH));
  assign range_empty = (left32 > right32) || (lo32 > hi32);

  // sequencer
  rslr_state_t state_r, state_nxt;
  logic        in_acc;
  logic        out_free;

  // scan datapath
  logic [AW-1:0]           addr_r;
  logic [AW-1:0]           hi_addr_r;
  logic signed [VAL_W-1:0] thr_r;
  logic [VAL_W-1:0]        rd_data_r;
  logic                    rd_vld_r;
  logic                    found_r;
  logic [VAL_W-1:0]        best_r;
  logic                    qualify;
  logic                    better;

  // load datapath
  logic signed [COEF_W+POS_W:0] prod_r;
  logic signed [VAL_W-1:0]      samp_r;
  logic [AW-1:0]                waddr_r;
  logic signed [VAL_W+1:0]      line_ext;
  logic signed [VAL_W+1:0]      diff;
  logic [VAL_W+1:0]             diff_abs;
  logic                         mem_we;

  // output register
  logic             out_vld_r;
  logic             out_found_r;
  logic [VAL_W-1:0] out_min_r;

  logic [VAL_W-1:0] mem [DEPTH];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == FUNC_LOAD) begin
            state_nxt = load_ok ? ST_LOAD_MUL : ST_IDLE;
          end else begin
            state_nxt = range_empty ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_LOAD_MUL: state_nxt = ST_LOAD_WR;
      ST_LOAD_WR: begin
        mem_we    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (addr_r == hi_addr_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      // last read word is compared during this cycle
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // residual: |sample - (slope*pos + offset)|, 34-bit signed intermediate
  assign line_ext = (VAL_W+2)'(prod_r) + (VAL_W+2)'(offset_r);
  assign diff     = (VAL_W+2)'(samp_r) - line_ext;
  assign diff_abs = diff[VAL_W+1] ? (VAL_W+2)'(-diff) : diff;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      prod_r  <= (COEF_W+POS_W+1)'(slope_r) * (COEF_W+POS_W+1)'($signed({1'b0, in_pos}));
      samp_r  <= in_val;
      waddr_r <= AW'(pos32 - 32'd1);
      addr_r    <= AW'(lo32 - 32'd1);
      hi_addr_r <= AW'(hi32 - 32'd1);
      thr_r     <= in_val;
    end else if (state_r == ST_SCAN) begin
      addr_r <= addr_r + AW'(1);
    end
  end

  // store with a write port and a registered read port: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr_r] <= diff_abs[VAL_W-1:0];
    end
    rd_data_r <= mem[addr_r];
  end

  // shared compare unit: strictly above threshold, then below running minimum
  assign qualify = $signed({1'b0, rd_data_r}) > $signed({thr_r[VAL_W-1], thr_r});
  assign better  = !found_r || (rd_data_r < best_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      rd_vld_r  <= (state_r == ST_SCAN);
      if (in_acc) begin
        found_r <= 1'b0;
      end else if (rd_vld_r && qualify && better) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      best_r <= '0;
    end else if (rd_vld_r && qualify && better) begin
      best_r <= rd_data_r;
    end
  end

  // result register, freed when the consumer takes the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_found_r <= found_r;
      out_min_r   <= found_r ? best_r : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_min_r;

endmodule

`default_nettype wire

FILE: rtl/core/rslr_checker.sv
`default_nettype none

module rslr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser
);

  import rslr_pkg::*;

  // not found always reports a zero minimum
  a_zero_when_missing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 32'd0))
    else $error("min_value not zero on a miss");

  // a query leaves the sequencer busy: in_tready goes low once it is accepted
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == FUNC_QUERY)) |=> !in_tready)
    else $error("ready right after a query");

  // a load never produces a result transaction
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == FUNC_LOAD) && !out_tvalid) |=> !out_tvalid)
    else $error("result after a load");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed under stall");

endmodule

bind range_successor_of_line_residuals_core rslr_checker u_rslr_checker (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

// block under test: range successor over line residuals
// loads store |sample - (slope*pos + offset)|, queries return the smallest
// stored residual above a signed threshold within left..right
// the store is not cleared by reset, so queries only ever span loaded positions

module testbench;
  import rslr_pkg::*;

  localparam int unsigned STORE_DEPTH = DEPTH_DEF;
  localparam int unsigned PAD_W       = IN_DATA_W - 3 * POS_W - VAL_W;
  localparam int          LONG_HOLD   = 3000;   // receiver hold-off, in cycles

  // one input transaction, fields at their block widths
  typedef struct {
    logic                    func;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        left;
    logic [POS_W-1:0]        right;
  } rslr_item_t;

  // one result transaction
  typedef struct {
    logic             found;
    logic [VAL_W-1:0] min_value;
  } successor_t;

  // directed stimulus row; want is used only where typed is set
  typedef struct {
    rslr_item_t item;
    bit         typed;
    successor_t want;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata  = '0;
  logic                 in_tuser  = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [VAL_W-1:0]     out_tdata;
  logic                 out_tuser;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr  = '0;
  logic [COEF_W-1:0]    cfg_wdata = '0;

  // predictor state: residual copy, which positions hold data, line coefficients
  logic [VAL_W-1:0]         residual_mirror [1:STORE_DEPTH];
  bit                       written [0:STORE_DEPTH+1];
  logic signed [COEF_W-1:0] slope_q  = '0;
  logic signed [COEF_W-1:0] offset_q = '0;

  successor_t pending_results [$];
  dir_row_t   dir_rows [$];
  int         fail_count   = 0;
  bit         idle_in_on   = 1'b1;
  bit         idle_out_on  = 1'b1;
  bit         long_hold_req = 1'b0;

  always #1 clk = ~clk;

  range_successor_of_line_residuals_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // position, value, left, right, zero pad (low to high)
    .in_tuser   (in_tuser),    // func
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // min_value
    .out_tuser  (out_tuser),   // found
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // residual of a sample against the current line, exact in 64 bits
  function automatic logic [VAL_W-1:0] line_residual(logic [POS_W-1:0] pos,
                                                     logic signed [VAL_W-1:0] sample);
    longint line;
    longint diff;
    line = longint'(slope_q) * longint'(pos) + longint'(offset_q);
    diff = longint'(sample) - line;
    if (diff < 0) diff = -diff;
    return diff[VAL_W-1:0];
  endfunction

  // smallest residual strictly above the threshold, clipped to the store
  function automatic successor_t scan_successor(rslr_item_t it);
    successor_t res;
    longint     lo;
    longint     hi;
    longint     p;
    res = '{found: 1'b0, min_value: '0};
    if (it.left <= it.right) begin
      lo = (it.left < 1) ? 1 : it.left;
      hi = (it.right > STORE_DEPTH) ? STORE_DEPTH : it.right;
      for (p = lo; p <= hi; p++) begin
        if (longint'(residual_mirror[p]) > longint'(it.value) &&
            (!res.found || residual_mirror[p] < res.min_value)) begin
          res.found     = 1'b1;
          res.min_value = residual_mirror[p];
        end
      end
    end
    return res;
  endfunction

  task automatic flag_error(string what, successor_t want, successor_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: expected found=%0b min=%0d, got found=%0b min=%0d",
               $realtime, what, want.found, want.min_value, got.found, got.min_value);
  endtask

  // offer one transaction, wait for the handshake, then update the predictor
  task automatic send_item(rslr_item_t it, bit typed, successor_t want);
    if (idle_in_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_W{1'b0}}, it.right, it.left, it.value, it.position};
    in_tuser  <= it.func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (it.func == FUNC_LOAD) begin
      // loads outside 1..depth are dropped by the block
      if (it.position >= 1 && it.position <= STORE_DEPTH) begin
        residual_mirror[it.position] = line_residual(it.position, it.value);
        written[it.position]         = 1'b1;
      end
    end else begin
      pending_results.push_back(typed ? want : scan_successor(it));
    end
  endtask

  task automatic dir_load(int pos, logic signed [VAL_W-1:0] sample);
    dir_row_t row;
    row.item  = '{func: FUNC_LOAD, position: POS_W'(pos), value: sample, left: '0,
                  right: '0};
    row.typed = 1'b0;
    row.want  = '{found: 1'b0, min_value: '0};
    dir_rows.push_back(row);
  endtask

  task automatic dir_query(int l, int r, logic signed [VAL_W-1:0] thr, bit typed,
                           logic found, logic [VAL_W-1:0] min_value);
    dir_row_t row;
    row.item  = '{func: FUNC_QUERY, position: '0, value: thr, left: POS_W'(l),
                  right: POS_W'(r)};
    row.typed = typed;
    row.want  = '{found: found, min_value: min_value};
    dir_rows.push_back(row);
  endtask

  // registers change only with the block idle: nothing pending, load finished
  task automatic set_line(logic signed [COEF_W-1:0] slope_v,
                          logic signed [COEF_W-1:0] offset_v);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_SLOPE;
    cfg_wdata <= slope_v;
    @(posedge clk);
    cfg_addr  <= REG_OFFSET;
    cfg_wdata <= offset_v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    slope_q  = slope_v;
    offset_q = offset_v;
  endtask

  // random traffic: loads grow loaded runs from both ends of the store,
  // queries mostly span a loaded run around a loaded anchor
  task automatic run_phase(int n_items);
    rslr_item_t it;
    successor_t none_res;
    int         done;
    int         sel;
    int         a;
    int         b;
    int         p;
    int         q;
    int         tries;
    int         span;
    longint     line;
    none_res = '{found: 1'b0, min_value: '0};
    done = 0;
    while (done < n_items) begin
      it = '{func: FUNC_LOAD, position: '0, value: '0, left: '0, right: '0};
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        // a: length of the loaded run from position 1, b: start of the run ending at depth
        a = 0;
        while (a < STORE_DEPTH && written[a + 1]) a++;
        b = STORE_DEPTH + 1;
        while (b > 1 && written[b - 1]) b--;
        sel = $urandom_range(0, 99);
        if (sel < 40 && a < STORE_DEPTH) p = a + 1;
        else if (sel < 55 && b > 1) p = b - 1;
        else if (sel < 80 && a > 0) p = $urandom_range(1, a);
        else if (sel < 95) p = $urandom_range(1, STORE_DEPTH);
        else p = $urandom_range(0, 1) ? 0 : $urandom_range(STORE_DEPTH + 1, 2047);
        it.position = POS_W'(p);
        line = longint'(slope_q) * p + longint'(offset_q);
        sel = $urandom_range(0, 9);
        if (sel < 4) it.value = VAL_W'(line + int'($urandom_range(0, 2000)) - 1000);
        else if (sel < 6) it.value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        else it.value = $urandom;
        // dropped loads do not count as traffic
        if (p >= 1 && p <= STORE_DEPTH) done++;
      end else begin
        it.func = FUNC_QUERY;
        if (sel < 63) begin
          // ranges that scan nothing
          case ($urandom_range(0, 2))
            0: begin
              it.left  = POS_W'($urandom_range(1, 2047));
              it.right = POS_W'($urandom_range(0, it.left - 1));
            end
            1: begin
              it.left  = '0;
              it.right = '0;
            end
            default: begin
              it.left  = POS_W'($urandom_range(STORE_DEPTH + 1, 2047));
              it.right = POS_W'($urandom_range(it.left, 2047));
            end
          endcase
          it.value = $urandom;
        end else begin
          p = 0;
          for (tries = 0; tries < 64 && p == 0; tries++) begin
            q = $urandom_range(1, STORE_DEPTH);
            if (written[q]) p = q;
          end
          if (p == 0) p = 1;   // position 1 is loaded by the directed part
          // mostly short scans, now and then one across the whole loaded run
          span = ($urandom_range(0, 9) == 0) ? STORE_DEPTH : $urandom_range(0, 24);
          a = p;
          while (a > 1 && written[a - 1] && p - a < span) a--;
          b = p;
          while (b < STORE_DEPTH && written[b + 1] && b - p < span) b++;
          it.left  = POS_W'(a);
          it.right = POS_W'(b);
          if (a == 1 && $urandom_range(0, 3) == 0) it.left = '0;
          if (b == STORE_DEPTH && $urandom_range(0, 1))
            it.right = POS_W'($urandom_range(b, 2047));
          // thresholds around a stored residual hit the strict-greater boundary
          q = $urandom_range(a, b);
          sel = $urandom_range(0, 9);
          if (sel < 4) it.value = VAL_W'(longint'(residual_mirror[q]) +
                                         int'($urandom_range(0, 2)) - 1);
          else if (sel < 6) begin
            case ($urandom_range(0, 3))
              0: it.value = 32'h8000_0000;
              1: it.value = 32'h7fff_ffff;
              2: it.value = 32'h0000_0000;
              default: it.value = 32'hffff_ffff;
            endcase
          end
          else if (sel < 8) it.value = int'($urandom_range(0, 4000)) - 2000;
          else it.value = $urandom;
        end
        done++;
      end
      send_item(it, 1'b0, none_res);
    end
    in_tvalid <= 1'b0;
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD - 1;
        out_tready   <= 1'b0;
      end else if (idle_out_on && $urandom_range(0, 7) == 0) begin
        hold_left   = $urandom_range(1, 18) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    successor_t got;
    successor_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{found: out_tuser, min_value: out_tdata};
      if (pending_results.size() == 0) begin
        want = '{found: 1'b0, min_value: '0};
        flag_error("result with nothing pending", want, got);
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found || got.min_value !== want.min_value)
          flag_error("result mismatch", want, got);
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #6000000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    int k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset line (slope 0, offset 0): residual is |sample|
    dir_load(1, 32'sd0);
    dir_load(2, 32'h7fff_ffff);
    dir_load(3, 32'h8000_0000);
    dir_load(4, -32'sd5);
    dir_load(STORE_DEPTH, 32'sd100);
    dir_load(STORE_DEPTH - 1, -32'sd1);
    dir_load(0, 32'sd77);                    // dropped, position below the store
    dir_load(STORE_DEPTH + 1, 32'sd9);       // dropped, position above the store
    dir_load(2047, 32'sd9);                  // dropped, all position bits set
    dir_query(1, 4, 32'h8000_0000, 1'b1, 1'b1, 32'd0);
    dir_query(1, 4, 32'sd0, 1'b1, 1'b1, 32'd5);
    dir_query(1, 4, 32'h7fff_ffff, 1'b1, 1'b1, 32'h8000_0000);
    dir_query(2, 2, 32'h7fff_ffff, 1'b1, 1'b0, 32'd0);     // nothing qualifies
    dir_query(0, 3, 32'sd4, 1'b0, 1'b0, 32'd0);            // left below the store
    dir_query(STORE_DEPTH - 1, 2047, 32'sd0, 1'b1, 1'b1, 32'd1);
    dir_query(STORE_DEPTH, STORE_DEPTH + 76, 32'sd100, 1'b1, 1'b0, 32'd0);
    dir_query(STORE_DEPTH, STORE_DEPTH, 32'sd99, 1'b1, 1'b1, 32'd100);
    dir_query(5, 4, 32'sd0, 1'b1, 1'b0, 32'd0);            // left above right
    dir_query(2047, 0, 32'h8000_0000, 1'b1, 1'b0, 32'd0);
    dir_query(STORE_DEPTH + 1, 2047, 32'h8000_0000, 1'b1, 1'b0, 32'd0);
    dir_query(0, 0, 32'h8000_0000, 1'b1, 1'b0, 32'd0);     // clips to nothing
    dir_load(4, 32'sd3);                                    // overwrite
    dir_query(4, 4, -32'sd1, 1'b1, 1'b1, 32'd3);
    dir_query(1, 4, 32'sd2, 1'b0, 1'b0, 32'd0);
    for (k = 0; k < dir_rows.size(); k++)
      send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
    in_tvalid <= 1'b0;

    // random part across several line settings, extremes first
    set_line(16'sh8000, 16'sh8000);
    run_phase(110);
    set_line(16'sh7fff, 16'sh7fff);
    long_hold_req = 1'b1;   // results back up while queries keep coming
    run_phase(110);
    set_line(COEF_W'($urandom), COEF_W'($urandom));
    run_phase(110);
    set_line(16'sh0000, COEF_W'($urandom));
    run_phase(110);
    set_line(16'sh7fff, 16'sh8000);
    // closing stretch without idling on either side
    idle_in_on  = 1'b0;
    idle_out_on = 1'b0;
    run_phase(116);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/rslr_pkg.sv
rtl/core/range_successor_of_line_residuals_core.sv
rtl/core/rslr_checker.sv
tb/sv/testbench.sv
